// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbb_pkg.sv =====
// Package for the LED blink and breathe mode sequencer.
// Holds register indexes, reset values and the structs shared by the modules.
`timescale 1ns / 1ps

package lbb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MODE_PERIOD   = 16'd5000;
    localparam logic [15:0] RST_BLINK_HALF    = 16'd1000;
    localparam logic [7:0]  RST_STEP_INTERVAL = 8'd10;
    localparam logic [15:0] RST_STEP_SIZE     = 16'd480;
    localparam logic [15:0] RST_DUTY_MAX      = 16'd48000;

    typedef struct packed {
        logic [15:0] mode_period;
        logic [15:0] blink_half_period;
        logic [7:0]  step_interval;
        logic [15:0] step_size;
        logic [15:0] duty_max;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic        led_level;
        logic [15:0] duty;
    } result_t;

endpackage

// ===== rtl/core/lbb_cfg_regs.sv =====
// Configuration register file of the LED blink and breathe sequencer.
// Depends on lbb_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module lbb_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data,
    output lbb_pkg::cfg_t                cfg
);
    import lbb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_period       <= RST_MODE_PERIOD;
            cfg_reg.blink_half_period <= RST_BLINK_HALF;
            cfg_reg.step_interval     <= RST_STEP_INTERVAL;
            cfg_reg.step_size         <= RST_STEP_SIZE;
            cfg_reg.duty_max          <= RST_DUTY_MAX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE_PERIOD:   cfg_reg.mode_period       <= cfg_data;
                REG_BLINK_HALF:    cfg_reg.blink_half_period <= cfg_data;
                REG_STEP_INTERVAL: cfg_reg.step_interval     <= cfg_data[7:0];
                REG_STEP_SIZE:     cfg_reg.step_size         <= cfg_data;
                REG_DUTY_MAX:      cfg_reg.duty_max          <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lbb_core.sv =====
// Sequencer state and its one-tick update logic.
// Depends on lbb_pkg (cfg_t, result_t) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbb_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             tick,
    input  lbb_pkg::cfg_t    cfg,
    output lbb_pkg::result_t res_next
);
    import lbb_pkg::*;

    logic        mode_reg,        mode_next;
    logic [15:0] mode_count_reg,  mode_count_next;
    logic [15:0] blink_count_reg, blink_count_next;
    logic        level_reg,       level_next;
    logic [7:0]  step_count_reg,  step_count_next;
    logic [15:0] duty_reg,        duty_next;
    logic        ramp_down_reg,   ramp_down_next;

    logic        switched;
    logic [16:0] mode_inc;
    logic [16:0] blink_inc;
    logic [8:0]  step_inc;
    logic [15:0] duty_base;
    logic        down_base;
    logic [16:0] ramp_val;

    always_comb
    begin
        mode_next        = mode_reg;
        mode_count_next  = mode_count_reg;
        blink_count_next = blink_count_reg;
        level_next       = level_reg;
        step_count_next  = step_count_reg;
        duty_next        = duty_reg;
        ramp_down_next   = ramp_down_reg;
        switched         = 1'b0;
        duty_base        = duty_reg;
        down_base        = ramp_down_reg;
        ramp_val         = 17'd0;

        mode_inc  = {1'b0, mode_count_reg} + 17'd1;
        blink_inc = {1'b0, blink_count_reg} + 17'd1;
        step_inc  = {1'b0, step_count_reg} + 9'd1;

        if (tick)
        begin
            // Mode counter first; a flip reinitializes the mode being entered.
            if (mode_inc >= {1'b0, cfg.mode_period})
            begin
                mode_count_next = 16'd0;
                switched        = 1'b1;
                mode_next       = ~mode_reg;
                if (mode_reg)
                begin
                    level_next       = 1'b1;
                    blink_count_next = 16'd0;
                end
                else
                begin
                    duty_base = 16'd0;
                    down_base = 1'b0;
                end
            end
            else
            begin
                mode_count_next = mode_inc[15:0];
            end
            duty_next      = duty_base;
            ramp_down_next = down_base;

            if (mode_next)
            begin
                // The step counter keeps running across mode changes.
                if (step_inc >= {1'b0, cfg.step_interval})
                begin
                    step_count_next = 8'd0;
                    if (down_base)
                        ramp_val = (duty_base > cfg.step_size) ?
                                   {1'b0, duty_base - cfg.step_size} : 17'd0;
                    else
                        ramp_val = {1'b0, duty_base} + {1'b0, cfg.step_size};
                    if (ramp_val >= {1'b0, cfg.duty_max})
                    begin
                        duty_next      = cfg.duty_max;
                        ramp_down_next = 1'b1;
                    end
                    else
                    begin
                        duty_next = ramp_val[15:0];
                        if (ramp_val == 17'd0)
                            ramp_down_next = 1'b0;
                    end
                end
                else
                begin
                    step_count_next = step_inc[7:0];
                end
            end
            else if (!switched)
            begin
                if (blink_inc >= {1'b0, cfg.blink_half_period})
                begin
                    blink_count_next = 16'd0;
                    level_next       = ~level_reg;
                end
                else
                begin
                    blink_count_next = blink_inc[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            mode_count_reg  <= 16'd0;
            blink_count_reg <= 16'd0;
            level_reg       <= 1'b1;
            step_count_reg  <= 8'd0;
            duty_reg        <= 16'd0;
            ramp_down_reg   <= 1'b0;
        end
        else if (adv)
        begin
            mode_reg        <= mode_next;
            mode_count_reg  <= mode_count_next;
            blink_count_reg <= blink_count_next;
            level_reg       <= level_next;
            step_count_reg  <= step_count_next;
            duty_reg        <= duty_next;
            ramp_down_reg   <= ramp_down_next;
        end
    end

    assign res_next.mode      = mode_next;
    assign res_next.led_level = level_next;
    assign res_next.duty      = duty_next;

    `ASSERT_NEXT(a_mode_count_bound, adv && tick && (cfg.mode_period != 16'd0),
        mode_count_reg < $past(cfg.mode_period), "mode counter passed its period")
    `ASSERT_NEXT(a_blink_entry, adv && tick && mode_reg && switched,
        !mode_reg && level_reg && (blink_count_reg == 16'd0), "blink entry not initialized")
    `ASSERT_NEXT(a_idle_hold, adv && !tick,
        $stable(mode_reg) && $stable(duty_reg) && $stable(level_reg), "state moved without tick")

endmodule

// ===== rtl/core/led_blink_breathe_mode_sequencer_unit.sv =====
// LED blink / breathe mode sequencer, top level.
// Each accepted tick passes the input register, then the result register.
// Throughput: one transaction per clock cycle while the output is not stalled.
// Reset (rst_n, asynchronous, active low): blink mode, LED on, counters and duty zero,
// configuration registers at their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The datapath is two registers deep. The input register captures each accepted tick
// transaction. Once the result register is ready, the core applies that tick to the
// sequencer state and the state after the update is captured, at the same edge, into
// the result register. The input stage moves forward whenever the result register is
// empty or is being drained, so a new transaction can enter while a finished result
// waits downstream. Configuration registers are read directly by the core; the user
// must change them only while the pipeline holds no transaction; this is not enforced.
module led_blink_breathe_mode_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           tick,
    // Output channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           mode,
    output logic                           led_level,
    output logic [15:0]                    duty,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lbb_pkg::*;

    cfg_t    cfg;
    result_t res_next;
    result_t res_reg;

    logic s1_valid_reg;
    logic s1_tick_reg;
    logic out_valid_reg;
    logic s2_ready;
    logic s2_load;
    logic in_accept;

    lbb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbb_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (s2_load),
        .tick     (s1_tick_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // The result register can take a new value when empty or when its value leaves now.
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s2_load   = s1_valid_reg && s2_ready;
    // The input register is free when empty or when its transaction moves on.
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;

            if (s2_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_tick_reg <= tick;
        if (s2_load)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign mode      = res_reg.mode;
    assign led_level = res_reg.led_level;
    assign duty      = res_reg.duty;

    `ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid_reg,
        "accepted transaction not held in input register")
    `ASSERT_NEXT(a_load_fills_s2, s2_load, out_valid_reg,
        "updated state not presented as a result")
    `ASSERT_CLK(a_no_overwrite, !(s2_load && out_valid_reg && out_stall),
        "result register overwritten while stalled")

endmodule
